// ----- rtl/ecr_pkg.sv -----
`default_nettype none
package ecr_pkg;

    // Field widths
    localparam int unsigned POS_W  = 24;
    localparam int unsigned MASS_W = 16;
    localparam int unsigned DT_W   = 16;
    localparam int unsigned EN_W   = 48;

    // Internal widths
    localparam int unsigned D_W    = 26;  // separation component
    localparam int unsigned SQ_W   = 52;  // |d|^2 and d.w
    localparam int unsigned MS_W   = 17;  // mass sum and 2*m2
    localparam int unsigned DEN_W  = SQ_W + MS_W;
    localparam int unsigned DIV_BITS = 27; // quotient is below 2*|w| < 2^26
    localparam int unsigned NUM_W  = DEN_W + DIV_BITS;

    localparam int unsigned IN_DATA_W  = 240;
    localparam int unsigned OUT_DATA_W = 104;

    typedef struct packed {
        logic signed [POS_W-1:0] own_pos_x;
        logic signed [POS_W-1:0] own_pos_y;
        logic signed [POS_W-1:0] own_vel_x;
        logic signed [POS_W-1:0] own_vel_y;
        logic signed [POS_W-1:0] other_pos_x;
        logic signed [POS_W-1:0] other_pos_y;
        logic signed [POS_W-1:0] other_vel_x;
        logic signed [POS_W-1:0] other_vel_y;
        logic [MASS_W-1:0]       own_mass;
        logic [MASS_W-1:0]       other_mass;
        logic [DT_W-1:0]         time_step;
    } in_t;

    // Per-pair context that rides alongside the divider
    typedef struct packed {
        logic signed [D_W-1:0]   dx;
        logic signed [D_W-1:0]   dy;
        logic signed [POS_W-1:0] vx;
        logic signed [POS_W-1:0] vy;
        logic [MASS_W-1:0]       m1;
        logic                    neg_x;
        logic                    neg_y;
        logic                    zero_x;
        logic                    zero_y;
        logic                    degen;
    } side_t;

endpackage
`default_nettype wire

// ----- rtl/ecr_front.sv -----
`default_nettype none
module ecr_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire ecr_pkg::in_t                     in_data,
    output logic                                  out_valid,
    output logic [ecr_pkg::NUM_W-1:0]             num_x,
    output logic [ecr_pkg::NUM_W-1:0]             num_y,
    output logic [ecr_pkg::DEN_W-1:0]             den,
    output ecr_pkg::side_t                        side
);

    // Stage 1: dt*v products
    logic                v1_reg;
    logic signed [23:0]  px1_reg, py1_reg, qx1_reg, qy1_reg;
    logic signed [23:0]  vx1_reg, vy1_reg, ux1_reg, uy1_reg;
    logic [15:0]         m1_1_reg, m2_1_reg;
    logic signed [40:0]  pvx1_reg, pvy1_reg, pux1_reg, puy1_reg;

    logic signed [16:0]  dt_s;
    assign dt_s = $signed({1'b0, in_data.time_step});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg  <= in_data.own_pos_x;
            py1_reg  <= in_data.own_pos_y;
            qx1_reg  <= in_data.other_pos_x;
            qy1_reg  <= in_data.other_pos_y;
            vx1_reg  <= in_data.own_vel_x;
            vy1_reg  <= in_data.own_vel_y;
            ux1_reg  <= in_data.other_vel_x;
            uy1_reg  <= in_data.other_vel_y;
            m1_1_reg <= in_data.own_mass;
            m2_1_reg <= in_data.other_mass;
            pvx1_reg <= dt_s * in_data.own_vel_x;
            pvy1_reg <= dt_s * in_data.own_vel_y;
            pux1_reg <= dt_s * in_data.other_vel_x;
            puy1_reg <= dt_s * in_data.other_vel_y;
        end
    end

    // Stage 2: advance positions (floor by arithmetic shift), form d and w
    logic                v2_reg;
    logic signed [25:0]  dx2_reg, dy2_reg;
    logic signed [24:0]  wx2_reg, wy2_reg;
    logic signed [23:0]  vx2_reg, vy2_reg;
    logic [15:0]         m1_2_reg;
    logic [16:0]         msum2_reg, m2x2_2_reg;

    logic signed [24:0]  apx, apy, aqx, aqy;
    assign apx = {px1_reg[23], px1_reg} + pvx1_reg[40:16];
    assign apy = {py1_reg[23], py1_reg} + pvy1_reg[40:16];
    assign aqx = {qx1_reg[23], qx1_reg} + pux1_reg[40:16];
    assign aqy = {qy1_reg[23], qy1_reg} + puy1_reg[40:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx2_reg    <= {apx[24], apx} - {aqx[24], aqx};
            dy2_reg    <= {apy[24], apy} - {aqy[24], aqy};
            wx2_reg    <= {vx1_reg[23], vx1_reg} - {ux1_reg[23], ux1_reg};
            wy2_reg    <= {vy1_reg[23], vy1_reg} - {uy1_reg[23], uy1_reg};
            vx2_reg    <= vx1_reg;
            vy2_reg    <= vy1_reg;
            m1_2_reg   <= m1_1_reg;
            msum2_reg  <= {1'b0, m1_1_reg} + {1'b0, m2_1_reg};
            m2x2_2_reg <= {m2_1_reg, 1'b0};
        end
    end

    // Stage 3: squares and d.w terms
    logic                v3_reg;
    logic signed [51:0]  dxx3_reg, dyy3_reg, dxw3_reg, dyw3_reg;
    logic signed [25:0]  dx3_reg, dy3_reg;
    logic signed [23:0]  vx3_reg, vy3_reg;
    logic [15:0]         m1_3_reg;
    logic [16:0]         msum3_reg, m2x2_3_reg;
    logic                deg3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxx3_reg   <= dx2_reg * dx2_reg;
            dyy3_reg   <= dy2_reg * dy2_reg;
            dxw3_reg   <= dx2_reg * wx2_reg;
            dyw3_reg   <= dy2_reg * wy2_reg;
            dx3_reg    <= dx2_reg;
            dy3_reg    <= dy2_reg;
            vx3_reg    <= vx2_reg;
            vy3_reg    <= vy2_reg;
            m1_3_reg   <= m1_2_reg;
            msum3_reg  <= msum2_reg;
            m2x2_3_reg <= m2x2_2_reg;
            deg3_reg   <= (dx2_reg == '0) && (dy2_reg == '0);
        end
    end

    // Stage 4: |d|^2 and d.w
    logic                v4_reg;
    logic [51:0]         d2_4_reg;
    logic signed [51:0]  dot4_reg;
    logic signed [25:0]  dx4_reg, dy4_reg;
    logic signed [23:0]  vx4_reg, vy4_reg;
    logic [15:0]         m1_4_reg;
    logic [16:0]         msum4_reg, m2x2_4_reg;
    logic                deg4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_4_reg   <= 52'(dxx3_reg) + 52'(dyy3_reg);
            dot4_reg   <= dxw3_reg + dyw3_reg;
            dx4_reg    <= dx3_reg;
            dy4_reg    <= dy3_reg;
            vx4_reg    <= vx3_reg;
            vy4_reg    <= vy3_reg;
            m1_4_reg   <= m1_3_reg;
            msum4_reg  <= msum3_reg;
            m2x2_4_reg <= m2x2_3_reg;
            deg4_reg   <= deg3_reg;
        end
    end

    // Stage 5: denominator, partial products of |d_i|*|d.w|, signs
    logic                v5_reg;
    logic [68:0]         den5_reg;
    logic [51:0]         pxa5_reg, pya5_reg;
    logic [50:0]         pxb5_reg, pyb5_reg;
    logic [16:0]         m2x2_5_reg;
    ecr_pkg::side_t      sd5_reg;

    logic [50:0]         mdot;
    logic [25:0]         adx, ady;
    assign mdot = dot4_reg[51] ? 51'(-dot4_reg) : 51'(dot4_reg);
    assign adx  = dx4_reg[25] ? 26'(-dx4_reg) : 26'(dx4_reg);
    assign ady  = dy4_reg[25] ? 26'(-dy4_reg) : 26'(dy4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den5_reg       <= d2_4_reg * msum4_reg;
            pxa5_reg       <= adx * mdot[25:0];
            pxb5_reg       <= adx * mdot[50:26];
            pya5_reg       <= ady * mdot[25:0];
            pyb5_reg       <= ady * mdot[50:26];
            m2x2_5_reg     <= m2x2_4_reg;
            sd5_reg.dx     <= dx4_reg;
            sd5_reg.dy     <= dy4_reg;
            sd5_reg.vx     <= vx4_reg;
            sd5_reg.vy     <= vy4_reg;
            sd5_reg.m1     <= m1_4_reg;
            sd5_reg.neg_x  <= dx4_reg[25] ^ dot4_reg[51];
            sd5_reg.neg_y  <= dy4_reg[25] ^ dot4_reg[51];
            sd5_reg.zero_x <= (dx4_reg == '0) || (dot4_reg == '0) || (m2x2_4_reg == '0);
            sd5_reg.zero_y <= (dy4_reg == '0) || (dot4_reg == '0) || (m2x2_4_reg == '0);
            sd5_reg.degen  <= deg4_reg;
        end
    end

    // Stage 6: assemble |d_i|*|d.w|
    logic                v6_reg;
    logic [77:0]         magx6_reg, magy6_reg;
    logic [68:0]         den6_reg;
    logic [16:0]         m2x2_6_reg;
    ecr_pkg::side_t      sd6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            magx6_reg  <= 78'(pxa5_reg) + {1'b0, pxb5_reg, 26'd0};
            magy6_reg  <= 78'(pya5_reg) + {1'b0, pyb5_reg, 26'd0};
            den6_reg   <= den5_reg;
            m2x2_6_reg <= m2x2_5_reg;
            sd6_reg    <= sd5_reg;
        end
    end

    // Stage 7: partial products with 2*m2
    logic                v7_reg;
    logic [55:0]         nxa7_reg, nxb7_reg, nya7_reg, nyb7_reg;
    logic [68:0]         den7_reg;
    ecr_pkg::side_t      sd7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxa7_reg <= magx6_reg[38:0] * m2x2_6_reg;
            nxb7_reg <= magx6_reg[77:39] * m2x2_6_reg;
            nya7_reg <= magy6_reg[38:0] * m2x2_6_reg;
            nyb7_reg <= magy6_reg[77:39] * m2x2_6_reg;
            den7_reg <= den6_reg;
            sd7_reg  <= sd6_reg;
        end
    end

    // Stage 8: full numerators
    logic                              v8_reg;
    logic [ecr_pkg::NUM_W-1:0]         numx8_reg, numy8_reg;
    logic [ecr_pkg::DEN_W-1:0]         den8_reg;
    ecr_pkg::side_t                    sd8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else if (en)
            v8_reg <= v7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx8_reg <= ecr_pkg::NUM_W'(nxa7_reg) + ecr_pkg::NUM_W'({nxb7_reg, 39'd0});
            numy8_reg <= ecr_pkg::NUM_W'(nya7_reg) + ecr_pkg::NUM_W'({nyb7_reg, 39'd0});
            den8_reg  <= den7_reg;
            sd8_reg   <= sd7_reg;
        end
    end

    assign out_valid = v8_reg;
    assign num_x     = numx8_reg;
    assign num_y     = numy8_reg;
    assign den       = den8_reg;
    assign side      = sd8_reg;

endmodule
`default_nettype wire

// ----- rtl/ecr_div.sv -----
`default_nettype none
module ecr_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [ecr_pkg::NUM_W-1:0]     num_x,
    input  wire logic [ecr_pkg::NUM_W-1:0]     num_y,
    input  wire logic [ecr_pkg::DEN_W-1:0]     den,
    input  wire ecr_pkg::side_t                in_side,
    output logic                               out_valid,
    output logic [ecr_pkg::DIV_BITS-1:0]       quo_x,
    output logic [ecr_pkg::DIV_BITS-1:0]       quo_y,
    output ecr_pkg::side_t                     out_side
);

    localparam int unsigned QB = ecr_pkg::DIV_BITS;
    localparam int unsigned RW = ecr_pkg::DEN_W;

    logic           v_reg   [1:QB];
    logic [RW-1:0]  rx_reg  [1:QB];
    logic [RW-1:0]  ry_reg  [1:QB];
    logic [QB-1:0]  nx_reg  [1:QB];
    logic [QB-1:0]  ny_reg  [1:QB];
    logic [QB-1:0]  qx_reg  [1:QB];
    logic [QB-1:0]  qy_reg  [1:QB];
    logic [RW-1:0]  den_reg [1:QB];
    ecr_pkg::side_t sd_reg  [1:QB];

    // One quotient bit per stage, restoring division in both lanes
    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        logic           v_in;
        logic [RW-1:0]  rx_in, ry_in, den_in;
        logic [QB-1:0]  nx_in, ny_in, qx_in, qy_in;
        ecr_pkg::side_t sd_in;
        logic [RW:0]    tx, ty;
        logic           gx, gy;

        if (k == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rx_in  = num_x[ecr_pkg::NUM_W-1:QB];
            assign ry_in  = num_y[ecr_pkg::NUM_W-1:QB];
            assign nx_in  = num_x[QB-1:0];
            assign ny_in  = num_y[QB-1:0];
            assign qx_in  = '0;
            assign qy_in  = '0;
            assign den_in = den;
            assign sd_in  = in_side;
        end
        else
        begin : g_rest
            assign v_in   = v_reg[k];
            assign rx_in  = rx_reg[k];
            assign ry_in  = ry_reg[k];
            assign nx_in  = nx_reg[k];
            assign ny_in  = ny_reg[k];
            assign qx_in  = qx_reg[k];
            assign qy_in  = qy_reg[k];
            assign den_in = den_reg[k];
            assign sd_in  = sd_reg[k];
        end

        assign tx = {rx_in, nx_in[QB-1]};
        assign ty = {ry_in, ny_in[QB-1]};
        assign gx = tx >= {1'b0, den_in};
        assign gy = ty >= {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[k+1]  <= gx ? RW'(tx - {1'b0, den_in}) : tx[RW-1:0];
                ry_reg[k+1]  <= gy ? RW'(ty - {1'b0, den_in}) : ty[RW-1:0];
                nx_reg[k+1]  <= {nx_in[QB-2:0], 1'b0};
                ny_reg[k+1]  <= {ny_in[QB-2:0], 1'b0};
                qx_reg[k+1]  <= {qx_in[QB-2:0], gx};
                qy_reg[k+1]  <= {qy_in[QB-2:0], gy};
                den_reg[k+1] <= den_in;
                sd_reg[k+1]  <= sd_in;
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign quo_x     = qx_reg[QB];
    assign quo_y     = qy_reg[QB];
    assign out_side  = sd_reg[QB];

endmodule
`default_nettype wire

// ----- rtl/ecr_back.sv -----
`default_nettype none
module ecr_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [ecr_pkg::DIV_BITS-1:0] quo_x,
    input  wire logic [ecr_pkg::DIV_BITS-1:0] quo_y,
    input  wire ecr_pkg::side_t               side,
    output logic                              out_valid,
    output logic signed [23:0]                new_vel_x,
    output logic signed [23:0]                new_vel_y,
    output logic [ecr_pkg::EN_W-1:0]          energy,
    output logic                              was_reversed,
    output logic                              degenerate,
    output logic                              saturated
);

    localparam logic signed [23:0] V_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] V_MIN = 24'sh800000;

    // Stage B1: apply velocity change and clip
    logic signed [27:0] cx, cy;
    logic signed [28:0] wx, wy;
    logic               sx, sy;
    logic signed [23:0] cnx, cny;

    assign cx = side.zero_x ? 28'sd0 :
                (side.neg_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x}));
    assign cy = side.zero_y ? 28'sd0 :
                (side.neg_y ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y}));
    assign wx = 29'(side.vx) - 29'(cx);
    assign wy = 29'(side.vy) - 29'(cy);

    always_comb
    begin
        sx  = 1'b0;
        sy  = 1'b0;
        cnx = wx[23:0];
        cny = wy[23:0];
        if (wx > 29'(V_MAX))
        begin
            cnx = V_MAX;
            sx  = 1'b1;
        end
        else if (wx < 29'(V_MIN))
        begin
            cnx = V_MIN;
            sx  = 1'b1;
        end
        if (wy > 29'(V_MAX))
        begin
            cny = V_MAX;
            sy  = 1'b1;
        end
        else if (wy < 29'(V_MIN))
        begin
            cny = V_MIN;
            sy  = 1'b1;
        end
    end

    logic               v1_reg;
    logic signed [23:0] nx1_reg, ny1_reg;
    logic signed [25:0] dx1_reg, dy1_reg;
    logic [15:0]        m1_1_reg;
    logic               deg1_reg, sat1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx1_reg  <= cnx;
            ny1_reg  <= cny;
            dx1_reg  <= side.dx;
            dy1_reg  <= side.dy;
            m1_1_reg <= side.m1;
            deg1_reg <= side.degen;
            sat1_reg <= sx | sy;
        end
    end

    // Stage B2: squares and d.v' terms
    logic               v2_reg;
    logic signed [47:0] sqx2_reg, sqy2_reg;
    logic signed [49:0] ndx2_reg, ndy2_reg;
    logic signed [23:0] nx2_reg, ny2_reg;
    logic [15:0]        m1_2_reg;
    logic               deg2_reg, sat2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx2_reg <= nx1_reg * nx1_reg;
            sqy2_reg <= ny1_reg * ny1_reg;
            ndx2_reg <= dx1_reg * nx1_reg;
            ndy2_reg <= dy1_reg * ny1_reg;
            nx2_reg  <= nx1_reg;
            ny2_reg  <= ny1_reg;
            m1_2_reg <= m1_1_reg;
            deg2_reg <= deg1_reg;
            sat2_reg <= sat1_reg;
        end
    end

    // Stage B3: |v'|^2 and d.v'
    logic               v3_reg;
    logic [47:0]        ss3_reg;
    logic signed [50:0] nd3_reg;
    logic signed [23:0] nx3_reg, ny3_reg;
    logic [15:0]        m1_3_reg;
    logic               deg3_reg, sat3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss3_reg  <= 48'(sqx2_reg) + 48'(sqy2_reg);
            nd3_reg  <= 51'(ndx2_reg) + 51'(ndy2_reg);
            nx3_reg  <= nx2_reg;
            ny3_reg  <= ny2_reg;
            m1_3_reg <= m1_2_reg;
            deg3_reg <= deg2_reg;
            sat3_reg <= sat2_reg;
        end
    end

    // Stage B4: energy, approach test and output register
    logic [63:0]        eprod;
    logic               rev;
    assign eprod = m1_3_reg * ss3_reg;
    assign rev   = nd3_reg[50];

    logic               ov_reg;
    logic signed [23:0] ox_reg, oy_reg;
    logic [47:0]        oe_reg;
    logic               orev_reg, odeg_reg, osat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oe_reg   <= 48'(eprod[63:17]);
            orev_reg <= rev;
            odeg_reg <= deg3_reg;
            if (rev)
            begin
                ox_reg   <= (nx3_reg == V_MIN) ? V_MAX : -nx3_reg;
                oy_reg   <= (ny3_reg == V_MIN) ? V_MAX : -ny3_reg;
                osat_reg <= sat3_reg | (nx3_reg == V_MIN) | (ny3_reg == V_MIN);
            end
            else
            begin
                ox_reg   <= nx3_reg;
                oy_reg   <= ny3_reg;
                osat_reg <= sat3_reg;
            end
        end
    end

    assign out_valid    = ov_reg;
    assign new_vel_x    = ox_reg;
    assign new_vel_y    = oy_reg;
    assign energy       = oe_reg;
    assign was_reversed = orev_reg;
    assign degenerate   = odeg_reg;
    assign saturated    = osat_reg;

endmodule
`default_nettype wire

// ----- rtl/elastic_collision_2d_resolve_top.sv -----
`default_nettype none
// Two-dimensional elastic collision resolver. Each beat on s_axis carries one
// particle pair (positions and velocities in Q8.16, masses, Q0.16 time step);
// each beat on m_axis returns the resolved own velocity, its kinetic energy in
// Q32.16 and three flags. The block takes one pair per clock unless m_axis
// stalls, and returns results in order through 8 front stages (position
// advance, dot products, numerator and denominator multiplies), 27 stages of
// the pipelined restoring divider (one quotient bit per stage), and 4 back
// stages (velocity update, energy, approach test, output register). A stall on
// m_axis halts the whole pipeline; s_axis_tready is low only while a result
// sits in the output register and m_axis_tready is low.
module elastic_collision_2d_resolve_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // own_pos_x, own_pos_y, own_vel_x, own_vel_y, other_pos_x, other_pos_y,
    // other_vel_x, other_vel_y, own_mass, other_mass, time_step
    input  wire logic [ecr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // new_vel_x, new_vel_y, energy, was_reversed, degenerate, saturated, zero pad
    output logic [ecr_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    logic                            en;
    ecr_pkg::in_t                    in_data;
    logic                            f_valid;
    logic [ecr_pkg::NUM_W-1:0]       f_num_x, f_num_y;
    logic [ecr_pkg::DEN_W-1:0]       f_den;
    ecr_pkg::side_t                  f_side;
    logic                            d_valid;
    logic [ecr_pkg::DIV_BITS-1:0]    d_qx, d_qy;
    ecr_pkg::side_t                  d_side;
    logic signed [23:0]              nvx, nvy;
    logic [ecr_pkg::EN_W-1:0]        nrg;
    logic                            rev, deg, sat;

    // Advance whenever the output register is free or being drained
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Unpack the input beat
    assign in_data.own_pos_x   = s_axis_tdata[23:0];
    assign in_data.own_pos_y   = s_axis_tdata[47:24];
    assign in_data.own_vel_x   = s_axis_tdata[71:48];
    assign in_data.own_vel_y   = s_axis_tdata[95:72];
    assign in_data.other_pos_x = s_axis_tdata[119:96];
    assign in_data.other_pos_y = s_axis_tdata[143:120];
    assign in_data.other_vel_x = s_axis_tdata[167:144];
    assign in_data.other_vel_y = s_axis_tdata[191:168];
    assign in_data.own_mass    = s_axis_tdata[207:192];
    assign in_data.other_mass  = s_axis_tdata[223:208];
    assign in_data.time_step   = s_axis_tdata[239:224];

    ecr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_data   (in_data),
        .out_valid (f_valid),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .den       (f_den),
        .side      (f_side)
    );

    ecr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .den       (f_den),
        .in_side   (f_side),
        .out_valid (d_valid),
        .quo_x     (d_qx),
        .quo_y     (d_qy),
        .out_side  (d_side)
    );

    ecr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (d_valid),
        .quo_x        (d_qx),
        .quo_y        (d_qy),
        .side         (d_side),
        .out_valid    (m_axis_tvalid),
        .new_vel_x    (nvx),
        .new_vel_y    (nvy),
        .energy       (nrg),
        .was_reversed (rev),
        .degenerate   (deg),
        .saturated    (sat)
    );

    // Pack the result beat
    assign m_axis_tdata = {5'd0, sat, deg, rev, nrg, nvy, nvx};

endmodule
`default_nettype wire

// ----- rtl/ecr_check.sv -----
`default_nettype none
module ecr_check (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          s_axis_tready,
    input wire logic          m_axis_tvalid,
    input wire logic          m_axis_tready,
    input wire logic [103:0]  m_axis_tdata
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Accept input exactly when the output side can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // Zero separation never reverses
    a_deg: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[97] |-> !m_axis_tdata[96])
        else $error("degenerate pair reported as reversed");

    // Keep the padding clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[103:99] == 5'd0)
        else $error("result padding not zero");

endmodule

bind elastic_collision_2d_resolve_top ecr_check u_ecr_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- dv/collision_checker.sv -----
`default_nettype none
module collision_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    input  wire logic          s_axis_tready,
    input  wire logic [239:0]  s_axis_tdata,
    input  wire logic          m_axis_tvalid,
    input  wire logic          m_axis_tready,
    input  wire logic [103:0]  m_axis_tdata,
    output int                 error_count,
    output int                 pending_count
);

    localparam longint VEL_MAX = 64'sd8388607;
    localparam longint VEL_MIN = -64'sd8388608;

    typedef struct {
        logic [23:0] vel_x;
        logic [23:0] vel_y;
        logic [47:0] energy;
        logic        reversed;
        logic        degenerate;
        logic        saturated;
    } resolved_t;

    resolved_t resolved_q[$];

    function automatic longint clip_vel(longint v, inout bit clipped);
        if (v > VEL_MAX)
        begin
            clipped = 1'b1;
            return VEL_MAX;
        end
        if (v < VEL_MIN)
        begin
            clipped = 1'b1;
            return VEL_MIN;
        end
        return v;
    endfunction

    // Impulse term d_i*(d.w)*2*m2 / (|d|^2*(m1+m2)), truncated toward zero
    function automatic longint impulse(longint di, longint dot, longint m2x2,
                                       logic [127:0] den);
        logic [127:0] num;
        logic [127:0] quo;
        longint       adi;
        longint       adot;
        if (di == 0 || dot == 0 || m2x2 == 0)
            return 0;
        adi  = (di < 0) ? -di : di;
        adot = (dot < 0) ? -dot : dot;
        num  = 128'(adi) * 128'(adot) * 128'(m2x2);
        quo  = num / den;
        quo  = {64'd0, quo[63:0]};
        if (quo > (128'd1 << 40))
            quo = 128'd1 << 40;
        return ((di < 0) != (dot < 0)) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    function automatic resolved_t resolve_pair(logic [239:0] d);
        resolved_t    r;
        longint       px, py, vx, vy, qx, qy, ux, uy, m1, m2, dt;
        longint       dx, dy, wx, wy, dot, d2, msum, nx, ny, nd, en;
        logic [127:0] den;
        bit           clipped;
        bit           rev;
        bit           deg;
        px = longint'($signed(d[23:0]));
        py = longint'($signed(d[47:24]));
        vx = longint'($signed(d[71:48]));
        vy = longint'($signed(d[95:72]));
        qx = longint'($signed(d[119:96]));
        qy = longint'($signed(d[143:120]));
        ux = longint'($signed(d[167:144]));
        uy = longint'($signed(d[191:168]));
        m1 = longint'({48'd0, d[207:192]});
        m2 = longint'({48'd0, d[223:208]});
        dt = longint'({48'd0, d[239:224]});
        clipped = 1'b0;
        rev = 1'b0;
        deg = 1'b0;

        // advance both particles, then separation and relative velocity
        dx = (px + ((dt * vx) >>> 16)) - (qx + ((dt * ux) >>> 16));
        dy = (py + ((dt * vy) >>> 16)) - (qy + ((dt * uy) >>> 16));
        wx = vx - ux;
        wy = vy - uy;
        nx = vx;
        ny = vy;
        if (dx == 0 && dy == 0)
            deg = 1'b1;
        else
        begin
            msum = m1 + m2;
            if (msum != 0)
            begin
                d2  = dx * dx + dy * dy;
                den = 128'(d2) * 128'(msum);
                dot = dx * wx + dy * wy;
                nx  = vx - impulse(dx, dot, 2 * m2, den);
                ny  = vy - impulse(dy, dot, 2 * m2, den);
            end
        end
        nx = clip_vel(nx, clipped);
        ny = clip_vel(ny, clipped);
        en = (m1 * (nx * nx + ny * ny)) >>> 17;

        // still approaching: flip the velocity
        nd = dx * nx + dy * ny;
        if (nd < 0)
        begin
            rev = 1'b1;
            nx  = clip_vel(-nx, clipped);
            ny  = clip_vel(-ny, clipped);
        end
        r.vel_x      = nx[23:0];
        r.vel_y      = ny[23:0];
        r.energy     = en[47:0];
        r.reversed   = rev;
        r.degenerate = deg;
        r.saturated  = clipped;
        return r;
    endfunction

    task automatic report(string name, logic [63:0] exp_v, logic [63:0] act_v);
        error_count++;
        if (error_count <= 10)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, name,
                     exp_v, act_v);
    endtask

    // Predict on accepted input beats, compare on accepted output beats
    always @(posedge clk)
    begin
        resolved_t exp_r;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                resolved_q.push_back(resolve_pair(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (resolved_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: result beat with none expected: %0h", $realtime,
                                 m_axis_tdata);
                end
                else
                begin
                    exp_r = resolved_q.pop_front();
                    if (m_axis_tdata[23:0] !== exp_r.vel_x)
                        report("new_vel_x", exp_r.vel_x, m_axis_tdata[23:0]);
                    if (m_axis_tdata[47:24] !== exp_r.vel_y)
                        report("new_vel_y", exp_r.vel_y, m_axis_tdata[47:24]);
                    if (m_axis_tdata[95:48] !== exp_r.energy)
                        report("energy", exp_r.energy, m_axis_tdata[95:48]);
                    if (m_axis_tdata[96] !== exp_r.reversed)
                        report("was_reversed", exp_r.reversed, m_axis_tdata[96]);
                    if (m_axis_tdata[97] !== exp_r.degenerate)
                        report("degenerate", exp_r.degenerate, m_axis_tdata[97]);
                    if (m_axis_tdata[98] !== exp_r.saturated)
                        report("saturated", exp_r.saturated, m_axis_tdata[98]);
                end
            end
            pending_count = resolved_q.size();
        end
    end

    initial
    begin
        error_count   = 0;
        pending_count = 0;
    end

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none
module testbench;

    localparam int RANDOM_PAIRS = 930;
    localparam int DRAIN_CYCLES = 60;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [239:0]  s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [103:0]  m_axis_tdata;
    int            error_count;
    int            pending_count;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    always #5 clk = ~clk;

    elastic_collision_2d_resolve_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    collision_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Stall the result side at random
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [239:0] pack_pair(logic [23:0] px, logic [23:0] py,
                                               logic [23:0] vx, logic [23:0] vy,
                                               logic [23:0] qx, logic [23:0] qy,
                                               logic [23:0] ux, logic [23:0] uy,
                                               logic [15:0] m1, logic [15:0] m2,
                                               logic [15:0] dt);
        return {dt, m2, m1, uy, ux, qy, qx, vy, vx, py, px};
    endfunction

    // Hand one pair over, with random gaps ahead of it
    task automatic send_pair(logic [239:0] pair);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pair;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
    endtask

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(4))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [239:0] random_pair();
        logic [23:0] px, py, vx, vy, qx, qy, ux, uy;
        logic [15:0] m1, m2, dt;
        px = 24'($urandom); py = 24'($urandom); vx = 24'($urandom); vy = 24'($urandom);
        qx = 24'($urandom); qy = 24'($urandom); ux = 24'($urandom); uy = 24'($urandom);
        m1 = 16'($urandom_range(65535, 1));
        m2 = 16'($urandom_range(65535, 1));
        dt = 16'($urandom);
        case ($urandom_range(5))
            // close pairs, where the collision actually matters
            0, 1:
            begin
                qx = px + 24'($signed($urandom_range(512)) - 256);
                qy = py + 24'($signed($urandom_range(512)) - 256);
                vx = 24'($signed($urandom_range(131072)) - 65536);
                vy = 24'($signed($urandom_range(131072)) - 65536);
                ux = 24'($signed($urandom_range(131072)) - 65536);
                uy = 24'($signed($urandom_range(131072)) - 65536);
                dt = 16'($urandom_range(255));
            end
            // close pairs with large velocities
            2:
            begin
                qx = px + 24'($signed($urandom_range(64)) - 32);
                qy = py + 24'($signed($urandom_range(64)) - 32);
                dt = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom);
            end
            // corner values in every field
            3:
            begin
                px = pick_coord(); py = pick_coord(); vx = pick_coord(); vy = pick_coord();
                qx = pick_coord(); qy = pick_coord(); ux = pick_coord(); uy = pick_coord();
                m1 = ($urandom_range(1) == 0) ? 16'hFFFF : 16'd1;
                m2 = ($urandom_range(1) == 0) ? 16'hFFFF : 16'd1;
                dt = ($urandom_range(1) == 0) ? 16'hFFFF : 16'd0;
            end
            // coincident after the step
            4:
            begin
                qx = px; qy = py; ux = vx; uy = vy;
            end
            default:
            begin
                m1 = 16'($urandom);
                m2 = 16'($urandom);
            end
        endcase
        return pack_pair(px, py, vx, vy, qx, qy, ux, uy, m1, m2, dt);
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and named corner cases
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_pair(pack_pair(24'h000000, 24'h000000, 24'h000100, 24'h000000,
                            24'h000000, 24'h000000, 24'h000100, 24'h000000,
                            16'd1, 16'd1, 16'd0));                   // zero separation
        send_pair(pack_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                            24'h800000, 24'h800000, 24'h800000, 24'h800000,
                            16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pair(pack_pair(24'h800000, 24'h800000, 24'h800000, 24'h800000,
                            24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                            16'hFFFF, 16'd1, 16'hFFFF));
        send_pair(pack_pair(24'h000000, 24'h000000, 24'h010000, 24'h000000,
                            24'h020000, 24'h000000, 24'h000000, 24'h000000,
                            16'd0, 16'd0, 16'd0));                   // zero mass sum
        send_pair(pack_pair(24'h000000, 24'h000000, 24'h000000, 24'h010000,
                            24'h010000, 24'h000000, 24'h000000, 24'h010000,
                            16'd5, 16'd5, 16'd0));                   // perpendicular
        send_pair(pack_pair(24'h000000, 24'h000000, 24'h800000, 24'h000000,
                            24'hFFFFFF, 24'h000000, 24'h800000, 24'h000000,
                            16'd7, 16'd3, 16'd0));                   // reversal clip
        send_pair(pack_pair(24'h000000, 24'h000000, 24'h7FFFFF, 24'h7FFFFF,
                            24'h000001, 24'h000000, 24'h800000, 24'h800000,
                            16'd1, 16'hFFFF, 16'd0));                // velocity clip
        send_pair(pack_pair(24'h000000, 24'h000000, 24'h010000, 24'h000000,
                            24'h000100, 24'h000000, 24'hFF0000, 24'h000000,
                            16'd100, 16'd100, 16'd0));               // head-on
        send_pair(pack_pair(24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                            24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000,
                            16'h8000, 16'h0001, 16'hFFFF));
        for (int k = 0; k < 11; k++)
            send_pair(random_pair());

        // drain completely before the random part
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        @(posedge clk);

        for (int k = 0; k < RANDOM_PAIRS; k++)
        begin
            if (k == RANDOM_PAIRS / 3)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 24;
            end
            else if (k == 2 * RANDOM_PAIRS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (k == 0)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 66;
            end
            send_pair(random_pair());
        end
        s_axis_tvalid <= 1'b0;

        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
